// ===== sv/stereo_tape_delay_top_defines.svh =====
// ----------------------------------------------------------------------------
// stereo tape delay assertion macros
// shared property forms used by the datapath checks
// ----------------------------------------------------------------------------
`ifndef STEREO_TAPE_DELAY_TOP_DEFINES_SVH
`define STEREO_TAPE_DELAY_TOP_DEFINES_SVH

// same-cycle implication
`define STDLY_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stereo tape delay check failed");

// next-cycle implication
`define STDLY_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stereo tape delay check failed");

`endif

// ===== sv/stdly_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdly_pkg
// types, constants and saturation helpers for the stereo tape delay
// ----------------------------------------------------------------------------
package stdly_pkg;

    localparam int DELAY_DEPTH_DEF     = 131072;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int SAMPLE_W = 24;
    localparam int STORE_W  = 27;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic [24:0] BASE_DELAY_RST = 25'd1228800;
    localparam logic [16:0] UNITY_Q15      = 17'd32768;
    localparam logic [15:0] WET_FLOOR      = 16'd32;
    localparam logic [16:0] SEVEN_TENTHS   = 17'd22938;

    localparam logic [16:0] SIN_C1 = 17'd2371;
    localparam logic [16:0] SIN_C2 = 17'd21062;
    localparam logic [16:0] SIN_C3 = 17'd51459;

    localparam logic signed [63:0] STORE_LIMIT = 64'sd41943040;
    localparam logic signed [63:0] OUT_MAX     = 64'sd8388607;
    localparam logic signed [63:0] OUT_MIN     = -64'sd8388608;
    localparam logic signed [63:0] I32_MAX     = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN     = -64'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_DELAY,
        CFG_FEEDBACK_GAIN,
        CFG_WET_GAIN,
        CFG_FLUTTER_DEPTH,
        CFG_FLUTTER_STEP,
        CFG_TONE_FILTER,
        CFG_LOOP_FILTER
    } t_cfg_idx;

    typedef struct packed {
        logic [24:0] base_delay;
        logic [15:0] feedback_gain;
        logic [15:0] wet_gain;
        logic [10:0] flutter_depth;
        logic [23:0] flutter_step;
        logic [47:0] tone_filter;
        logic [47:0] loop_filter;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic take;
    } t_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_stat;

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                  input logic signed [63:0] lo,
                                                  input logic signed [63:0] hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = clamp64(v, I32_MIN, I32_MAX);
        return c[31:0];
    endfunction

endpackage

// ===== sv/stereo_tape_delay_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_tape_delay_top
// modulated stereo feedback delay with tone and loop filters
//
//   channel   signals                               direction
//   in        i_in_valid o_in_ready i_left_in ...   sample pair in
//   out       o_out_valid i_out_ready o_left_out .. mixed pair out
//   cfg       i_cfg_valid o_cfg_ready index data    register write
//
// a processed pair makes one pass of a single shared 33 x 28 multiplier
// through lfo, delay, filters and mix; a pass-through pair (wet at or below
// floor) goes from idle straight to done
// the next pair is accepted in the cycle after the result moves to the output
// register, so a stalled output holds the sequencer after one pair
// reset is synchronous; delay stores need no clearing, a fill mark masks
// entries not yet written
// ----------------------------------------------------------------------------
module stereo_tape_delay_top #(
    parameter int DELAY_DEPTH     = stdly_pkg::DELAY_DEPTH_DEF,
    parameter int SINE_TABLE_BITS = stdly_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [stdly_pkg::SAMPLE_W-1:0] i_left_in,
    input  logic signed [stdly_pkg::SAMPLE_W-1:0] i_right_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [stdly_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [stdly_pkg::SAMPLE_W-1:0] o_right_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [stdly_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [stdly_pkg::CFG_W-1:0]        i_cfg_data
);
    import stdly_pkg::*;

    t_cfg               r_cfg;
    t_ctl               ctl;
    t_stat              stat;
    logic               r_out_valid;
    logic signed [23:0] r_left_out;
    logic signed [23:0] r_right_out;
    logic signed [23:0] core_l;
    logic signed [23:0] core_r;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = stat.idle;
    assign ctl.start   = i_in_valid && stat.idle;
    assign ctl.take    = stat.done && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_delay    <= BASE_DELAY_RST;
            r_cfg.feedback_gain <= '0;
            r_cfg.wet_gain      <= '0;
            r_cfg.flutter_depth <= '0;
            r_cfg.flutter_step  <= '0;
            r_cfg.tone_filter   <= '0;
            r_cfg.loop_filter   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BASE_DELAY:    r_cfg.base_delay    <= i_cfg_data[24:0];
                CFG_FEEDBACK_GAIN: r_cfg.feedback_gain <= i_cfg_data[15:0];
                CFG_WET_GAIN:      r_cfg.wet_gain      <= i_cfg_data[15:0];
                CFG_FLUTTER_DEPTH: r_cfg.flutter_depth <= i_cfg_data[10:0];
                CFG_FLUTTER_STEP:  r_cfg.flutter_step  <= i_cfg_data[23:0];
                CFG_TONE_FILTER:   r_cfg.tone_filter   <= i_cfg_data;
                CFG_LOOP_FILTER:   r_cfg.loop_filter   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.take) begin
            r_out_valid <= 1'b1;
            r_left_out  <= core_l;
            r_right_out <= core_r;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    stdly_core #(
        .DELAY_DEPTH     (DELAY_DEPTH),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ctl   (ctl),
        .i_left  (i_left_in),
        .i_right (i_right_in),
        .o_stat  (stat),
        .o_left  (core_l),
        .o_right (core_r)
    );

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

endmodule

// ===== sv/stdly_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdly_ram
// single write, single read sample store with registered read data
// ----------------------------------------------------------------------------
module stdly_ram #(
    parameter int DEPTH = stdly_pkg::DELAY_DEPTH_DEF,
    parameter int AW    = $clog2(stdly_pkg::DELAY_DEPTH_DEF),
    parameter int DW    = stdly_pkg::STORE_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/stdly_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdly_core
// sequencer with one shared multiplier over the two delay stores
// ----------------------------------------------------------------------------
`include "stereo_tape_delay_top_defines.svh"
module stdly_core #(
    parameter int DELAY_DEPTH     = stdly_pkg::DELAY_DEPTH_DEF,
    parameter int SINE_TABLE_BITS = stdly_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stdly_pkg::t_cfg     i_cfg,
    input  stdly_pkg::t_ctl     i_ctl,
    input  logic signed [23:0]  i_left,
    input  logic signed [23:0]  i_right,
    output stdly_pkg::t_stat    o_stat,
    output logic signed [23:0]  o_left,
    output logic signed [23:0]  o_right
);
    import stdly_pkg::*;

    localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int QB = SINE_TABLE_BITS - 2;
    localparam logic [AW-1:0] LAST    = AW'(DELAY_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X = (AW+1)'(DELAY_DEPTH);
    localparam logic signed [32:0] D_LO = 33'sd256;
    localparam logic signed [32:0] D_HI = 33'((DELAY_DEPTH - 2) * 256);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SIN0, ST_SIN1, ST_SIN2, ST_SIN3, ST_SIN4,
        ST_MOD0, ST_MOD1, ST_MOD2, ST_DMUL, ST_DLY,
        ST_RD1, ST_RD2, ST_RD3, ST_INT,
        ST_BQ0, ST_BQ1, ST_BQ2, ST_BQ3, ST_BQ4,
        ST_FB, ST_WR, ST_MIX0, ST_MIX1, ST_DONE
    } t_state;

    t_state              r_state;
    logic [23:0]         r_phase;
    logic [AW-1:0]       r_wp;
    logic                r_full;
    logic                r_ch;
    logic                r_flt;
    logic signed [60:0]  r_prod;
    logic [16:0]         r_x2;
    logic signed [16:0]  r_sine;
    logic signed [27:0]  r_m;
    logic signed [27:0]  r_mr;
    logic [AW-1:0]       r_n;
    logic [7:0]          r_frac;
    logic [AW-1:0]       r_p1;
    logic                r_ok;
    logic signed [26:0]  r_s1;
    logic signed [32:0]  r_x;
    logic signed [48:0]  r_bx;
    logic signed [31:0]  r_y;
    logic signed [31:0]  r_tone;
    logic signed [41:0]  r_acc;
    logic signed [23:0]  r_in_l;
    logic signed [23:0]  r_in_r;
    logic signed [23:0]  r_out_l;
    logic signed [23:0]  r_out_r;
    logic signed [31:0]  r_tone_s [4];
    logic signed [31:0]  r_loop_s [4];

    logic signed [32:0]  op_a;
    logic signed [27:0]  op_b;
    logic signed [60:0]  prod;
    logic signed [63:0]  p64;

    logic [SINE_TABLE_BITS-1:0] sidx;
    logic [1:0]          quad;
    logic [15:0]         xraw;
    logic [16:0]         x17;
    logic [16:0]         n_x2;
    logic [16:0]         t1;
    logic [16:0]         t2;
    logic [16:0]         s17;
    logic [15:0]         sabs;
    logic signed [16:0]  n_sine;
    logic signed [27:0]  m28;
    logic signed [63:0]  sh15;
    logic signed [27:0]  msh;
    logic signed [27:0]  n_mr;
    logic signed [63:0]  sh31;
    logic signed [32:0]  dly;
    logic signed [32:0]  dlyc;
    logic [AW:0]         pdiff;
    logic [AW:0]         pwrap;
    logic [AW-1:0]       p1;
    logic [AW-1:0]       p2;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [26:0]         rd_l;
    logic [26:0]         rd_r;
    logic signed [26:0]  rd_sel;
    logic signed [26:0]  s2v;
    logic signed [27:0]  dif;
    logic signed [63:0]  sh8;
    logic signed [32:0]  n_x;
    logic [1:0]          s_idx0;
    logic [1:0]          s_idx1;
    logic signed [31:0]  st_s1;
    logic signed [31:0]  st_s2;
    logic signed [15:0]  cb0;
    logic signed [15:0]  ca1;
    logic signed [15:0]  ca2;
    logic signed [31:0]  n_y;
    logic signed [31:0]  n_s1;
    logic signed [31:0]  n_s2;
    logic [16:0]         fb17;
    logic [16:0]         wet17;
    logic [16:0]         dry17;
    logic signed [23:0]  in_ch;
    logic signed [63:0]  wsum;
    logic signed [63:0]  wcl;
    logic                we_l;
    logic                we_r;
    logic signed [63:0]  mixv;
    logic signed [63:0]  mixc;
    logic [AW-1:0]       wp_next;

    assign prod = op_a * op_b;
    assign p64  = 64'(r_prod);

    always_comb begin
        sidx  = r_phase[23 -: SINE_TABLE_BITS];
        quad  = sidx[SINE_TABLE_BITS-1 -: 2];
        xraw  = 16'(sidx[QB-1:0]) << (15 - QB);
        x17   = quad[0] ? (UNITY_Q15 - {1'b0, xraw}) : {1'b0, xraw};
        n_x2  = r_prod[31:15];
        t1    = SIN_C2 - r_prod[31:15];
        t2    = SIN_C3 - r_prod[31:15];
        s17   = r_prod[31:15];
        sabs  = (s17 > 17'd32767) ? 16'd32767 : s17[15:0];
        n_sine = quad[1] ? -$signed({1'b0, sabs}) : $signed({1'b0, sabs});
        m28   = r_prod[27:0];
        sh15  = p64 >>> 15;
        msh   = sh15[27:0];
        n_mr  = -msh;
        sh31  = p64 >>> 31;
        dly   = $signed({8'd0, i_cfg.base_delay}) + $signed(sh31[32:0]);
        if (dly < D_LO) begin
            dlyc = D_LO;
        end else if (dly > D_HI) begin
            dlyc = D_HI;
        end else begin
            dlyc = dly;
        end
        pdiff = {1'b0, r_wp} - {1'b0, r_n};
        pwrap = pdiff + DEPTH_X;
        p1    = pdiff[AW] ? pwrap[AW-1:0] : pdiff[AW-1:0];
        p2    = (r_p1 == '0) ? LAST : (r_p1 - AW'(1));
        rd_sel = r_ch ? $signed(rd_r) : $signed(rd_l);
        s2v   = r_ok ? rd_sel : '0;
        dif   = 28'(s2v) - 28'(r_s1);
        sh8   = p64 >>> 8;
        n_x   = 33'(r_s1) + $signed(sh8[32:0]);
        s_idx0 = {r_ch, 1'b0};
        s_idx1 = {r_ch, 1'b1};
        st_s1 = r_flt ? r_loop_s[s_idx0] : r_tone_s[s_idx0];
        st_s2 = r_flt ? r_loop_s[s_idx1] : r_tone_s[s_idx1];
        cb0   = r_flt ? i_cfg.loop_filter[47:32] : i_cfg.tone_filter[47:32];
        ca1   = r_flt ? i_cfg.loop_filter[31:16] : i_cfg.tone_filter[31:16];
        ca2   = r_flt ? i_cfg.loop_filter[15:0]  : i_cfg.tone_filter[15:0];
        n_y   = sat32((p64 >>> 14) + 64'(st_s1));
        n_s1  = sat32((((64'(r_bx) <<< 1) - p64) >>> 14) + 64'(st_s2));
        n_s2  = sat32((64'(r_bx) - p64) >>> 14);
        fb17  = (i_cfg.feedback_gain > UNITY_Q15[15:0] && i_cfg.feedback_gain[15])
                ? UNITY_Q15 : {1'b0, i_cfg.feedback_gain};
        wet17 = (i_cfg.wet_gain > UNITY_Q15[15:0] && i_cfg.wet_gain[15])
                ? UNITY_Q15 : {1'b0, i_cfg.wet_gain};
        dry17 = UNITY_Q15 - wet17;
        in_ch = r_ch ? r_in_r : r_in_l;
        wsum  = 64'(in_ch) + (p64 >>> 15);
        wcl   = clamp64(wsum, -STORE_LIMIT, STORE_LIMIT);
        we_l  = (r_state == ST_WR) && !r_ch;
        we_r  = (r_state == ST_WR) && r_ch;
        mixv  = (64'(r_acc) + p64) >>> 15;
        mixc  = clamp64(mixv, OUT_MIN, OUT_MAX);
        wp_next = (r_wp == LAST) ? '0 : (r_wp + AW'(1));
        rd_en   = (r_state == ST_RD1) || (r_state == ST_RD2);
        rd_addr = (r_state == ST_RD1) ? p1 : p2;
    end

    // operand select for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_state)
            ST_SIN0: begin
                op_a = $signed({16'd0, x17});
                op_b = $signed({11'd0, x17});
            end
            ST_SIN1: begin
                op_a = $signed({16'd0, SIN_C1});
                op_b = $signed({11'd0, n_x2});
            end
            ST_SIN2: begin
                op_a = $signed({16'd0, t1});
                op_b = $signed({11'd0, r_x2});
            end
            ST_SIN3: begin
                op_a = $signed({16'd0, t2});
                op_b = $signed({11'd0, x17});
            end
            ST_MOD0: begin
                op_a = 33'(r_sine);
                op_b = $signed({17'd0, i_cfg.flutter_depth});
            end
            ST_MOD1: begin
                op_a = 33'(m28);
                op_b = $signed({11'd0, SEVEN_TENTHS});
            end
            ST_DMUL: begin
                op_a = $signed({8'd0, i_cfg.base_delay});
                op_b = r_ch ? r_mr : r_m;
            end
            ST_RD3: begin
                op_a = 33'(dif);
                op_b = $signed({20'd0, r_frac});
            end
            ST_BQ0: begin
                op_a = r_x;
                op_b = 28'(cb0);
            end
            ST_BQ2: begin
                op_a = 33'(r_y);
                op_b = 28'(ca1);
            end
            ST_BQ3: begin
                op_a = 33'(r_y);
                op_b = 28'(ca2);
            end
            ST_FB: begin
                op_a = 33'(r_y);
                op_b = $signed({11'd0, fb17});
            end
            ST_WR: begin
                op_a = 33'(in_ch);
                op_b = $signed({11'd0, dry17});
            end
            ST_MIX0: begin
                op_a = 33'(r_tone);
                op_b = $signed({11'd0, wet17});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= '0;
            r_wp    <= '0;
            r_full  <= 1'b0;
            r_ch    <= 1'b0;
            r_flt   <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_tone_s[i] <= '0;
                r_loop_s[i] <= '0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_ctl.start) begin
                        r_in_l <= i_left;
                        r_in_r <= i_right;
                        r_ch   <= 1'b0;
                        if (i_cfg.wet_gain <= WET_FLOOR) begin
                            r_out_l <= i_left;
                            r_out_r <= i_right;
                            r_state <= ST_DONE;
                        end else begin
                            r_phase <= r_phase + i_cfg.flutter_step;
                            r_state <= ST_SIN0;
                        end
                    end
                end
                ST_SIN0: r_state <= ST_SIN1;
                ST_SIN1: begin
                    r_x2    <= n_x2;
                    r_state <= ST_SIN2;
                end
                ST_SIN2: r_state <= ST_SIN3;
                ST_SIN3: r_state <= ST_SIN4;
                ST_SIN4: begin
                    r_sine  <= n_sine;
                    r_state <= ST_MOD0;
                end
                ST_MOD0: r_state <= ST_MOD1;
                ST_MOD1: begin
                    r_m     <= m28;
                    r_state <= ST_MOD2;
                end
                ST_MOD2: begin
                    r_mr    <= n_mr;
                    r_state <= ST_DMUL;
                end
                ST_DMUL: r_state <= ST_DLY;
                ST_DLY: begin
                    r_n     <= dlyc[8 +: AW];
                    r_frac  <= dlyc[7:0];
                    r_state <= ST_RD1;
                end
                ST_RD1: begin
                    r_p1    <= p1;
                    r_ok    <= r_full || (p1 < r_wp);
                    r_state <= ST_RD2;
                end
                ST_RD2: begin
                    r_s1    <= r_ok ? rd_sel : '0;
                    r_ok    <= r_full || (p2 < r_wp);
                    r_state <= ST_RD3;
                end
                ST_RD3: r_state <= ST_INT;
                ST_INT: begin
                    r_x     <= n_x;
                    r_flt   <= 1'b0;
                    r_state <= ST_BQ0;
                end
                ST_BQ0: r_state <= ST_BQ1;
                ST_BQ1: begin
                    r_bx    <= r_prod[48:0];
                    r_y     <= n_y;
                    r_state <= ST_BQ2;
                end
                ST_BQ2: r_state <= ST_BQ3;
                ST_BQ3: begin
                    if (r_flt) begin
                        r_loop_s[s_idx0] <= n_s1;
                    end else begin
                        r_tone_s[s_idx0] <= n_s1;
                    end
                    r_state <= ST_BQ4;
                end
                ST_BQ4: begin
                    if (r_flt) begin
                        r_loop_s[s_idx1] <= n_s2;
                        r_state <= ST_FB;
                    end else begin
                        r_tone_s[s_idx1] <= n_s2;
                        r_tone  <= r_y;
                        r_x     <= 33'(r_y);
                        r_flt   <= 1'b1;
                        r_state <= ST_BQ0;
                    end
                end
                ST_FB: r_state <= ST_WR;
                ST_WR: r_state <= ST_MIX0;
                ST_MIX0: begin
                    r_acc   <= r_prod[41:0];
                    r_state <= ST_MIX1;
                end
                ST_MIX1: begin
                    if (!r_ch) begin
                        r_out_l <= mixc[23:0];
                        r_ch    <= 1'b1;
                        r_state <= ST_DMUL;
                    end else begin
                        r_out_r <= mixc[23:0];
                        r_wp    <= wp_next;
                        if (r_wp == LAST) begin
                            r_full <= 1'b1;
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_ctl.take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    stdly_ram #(.DEPTH(DELAY_DEPTH), .AW(AW), .DW(STORE_W)) u_left_store (
        .i_clk   (i_clk),
        .i_we    (we_l),
        .i_waddr (r_wp),
        .i_wdata (wcl[26:0]),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_l)
    );

    stdly_ram #(.DEPTH(DELAY_DEPTH), .AW(AW), .DW(STORE_W)) u_right_store (
        .i_clk   (i_clk),
        .i_we    (we_r),
        .i_waddr (r_wp),
        .i_wdata (wcl[26:0]),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_r)
    );

    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE);
    assign o_left  = r_out_l;
    assign o_right = r_out_r;

    `STDLY_ASSERT_IMPL(a_rd_not_wp, i_clk, i_rst_n, rd_en, rd_addr != r_wp)
    `STDLY_ASSERT_IMPL(a_tap_range, i_clk, i_rst_n, r_state == ST_RD1, (r_n != '0) && (r_n < LAST))
    `STDLY_ASSERT_NEXT(a_full_sticky, i_clk, i_rst_n, r_full, r_full)
    `STDLY_ASSERT_NEXT(a_wp_hold, i_clk, i_rst_n, r_state != ST_MIX1, $stable(r_wp))

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo tape delay testbench
// drives sample pairs and register writes through valid/ready channels with
// random gaps and output stalls; a fixed-point model of the modulated delay,
// tone and loop filters and dry/wet mix predicts every output pair
// ----------------------------------------------------------------------------
module tb;
    import stdly_pkg::*;

    localparam int DEPTH = 131072;
    localparam int SINE_BITS = 10;
    localparam int SINE_N = 1 << SINE_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int LATENCY = 60;
    localparam int CYCLE_LIMIT = 600000;

    class tape_delay_scoreboard;
        int left_mem[DEPTH];
        int right_mem[DEPTH];
        int sine[SINE_N];
        int tone_s[4];
        int loop_s[4];
        int wr_ptr;
        logic [23:0] phase;
        t_cfg cfg;
        logic [23:0] left_q[$];
        logic [23:0] right_q[$];
        int errors;
        int results;

        function new();
            longint x, x2, t, s;
            int q;
            for (int i = 0; i < SINE_N; i++) begin
                q = (i >> (SINE_BITS - 2)) & 3;
                x = longint'(i & ((1 << (SINE_BITS - 2)) - 1)) << (15 - (SINE_BITS - 2));
                if (q[0]) x = 32768 - x;
                x2 = (x * x) >>> 15;
                t = 21062 - ((2371 * x2) >>> 15);
                t = 51459 - ((t * x2) >>> 15);
                s = (t * x) >>> 15;
                if (s > 32767) s = 32767;
                sine[i] = q[1] ? -int'(s) : int'(s);
            end
            for (int i = 0; i < DEPTH; i++) begin
                left_mem[i] = 0;
                right_mem[i] = 0;
            end
            for (int i = 0; i < 4; i++) begin
                tone_s[i] = 0;
                loop_s[i] = 0;
            end
            wr_ptr = 0;
            phase = '0;
            cfg = '0;
            cfg.base_delay = BASE_DELAY_RST;
            errors = 0;
            results = 0;
        endfunction

        function longint limit(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] d);
            case (idx)
                CFG_BASE_DELAY:    cfg.base_delay = d[24:0];
                CFG_FEEDBACK_GAIN: cfg.feedback_gain = d[15:0];
                CFG_WET_GAIN:      cfg.wet_gain = d[15:0];
                CFG_FLUTTER_DEPTH: cfg.flutter_depth = d[10:0];
                CFG_FLUTTER_STEP:  cfg.flutter_step = d[23:0];
                CFG_TONE_FILTER:   cfg.tone_filter = d;
                CFG_LOOP_FILTER:   cfg.loop_filter = d;
                default: ;
            endcase
        endfunction

        function longint biquad(logic [47:0] c, longint x, inout int s1, inout int s2);
            longint b0, a1, a2, y;
            b0 = longint'($signed(c[47:32]));
            a1 = longint'($signed(c[31:16]));
            a2 = longint'($signed(c[15:0]));
            y = limit(((b0 * x) >>> 14) + s1, I32_MIN, I32_MAX);
            s1 = int'(limit(((2 * b0 * x - a1 * y) >>> 14) + s2, I32_MIN, I32_MAX));
            s2 = int'(limit((b0 * x - a2 * y) >>> 14, I32_MIN, I32_MAX));
            return y;
        endfunction

        function longint run_channel(bit right, longint factor, longint din,
                                     longint fb, longint wet);
            longint d, frac, v1, v2, rd, tone, lp;
            int n, p1, p2, k;
            d = (longint'(cfg.base_delay) * factor) >>> 31;
            d = limit(d, 256, longint'(DEPTH - 2) * 256);
            n = int'(d >>> 8);
            frac = d & 255;
            p1 = (wr_ptr + DEPTH - n) % DEPTH;
            p2 = (wr_ptr + DEPTH - n - 1) % DEPTH;
            v1 = right ? right_mem[p1] : left_mem[p1];
            v2 = right ? right_mem[p2] : left_mem[p2];
            rd = v1 + ((frac * (v2 - v1)) >>> 8);
            k = right ? 2 : 0;
            tone = biquad(cfg.tone_filter, rd, tone_s[k], tone_s[k+1]);
            lp = biquad(cfg.loop_filter, tone, loop_s[k], loop_s[k+1]);
            d = limit(din + ((lp * fb) >>> 15), -STORE_LIMIT, STORE_LIMIT);
            if (right) right_mem[wr_ptr] = int'(d);
            else left_mem[wr_ptr] = int'(d);
            return limit((din * (32768 - wet) + tone * wet) >>> 15, OUT_MIN, OUT_MAX);
        endfunction

        function void note_request(logic signed [23:0] l, logic signed [23:0] r);
            longint wet, fb, m;
            if (cfg.wet_gain <= WET_FLOOR) begin
                left_q.push_back(l);
                right_q.push_back(r);
                return;
            end
            wet = cfg.wet_gain > 32768 ? 32768 : cfg.wet_gain;
            fb = cfg.feedback_gain > 32768 ? 32768 : cfg.feedback_gain;
            phase = phase + cfg.flutter_step;
            m = longint'(sine[phase[23 -: SINE_BITS]]) * longint'(cfg.flutter_depth);
            left_q.push_back(24'(run_channel(0, (64'sd1 << 31) + m, l, fb, wet)));
            right_q.push_back(24'(run_channel(1, (64'sd1 << 31) - ((m * 22938) >>> 15),
                                              r, fb, wet)));
            wr_ptr = (wr_ptr + 1) % DEPTH;
        endfunction

        task report(string what, logic [23:0] got, logic [23:0] want);
            $display("mismatch %s at result %0d: got %h want %h", what, results, got, want);
            errors++;
        endtask

        task check_result(logic [23:0] l, logic [23:0] r);
            logic [23:0] el, er;
            if (left_q.size() == 0) begin
                report("unexpected pair, left and right", l, r);
            end else begin
                el = left_q.pop_front();
                er = right_q.pop_front();
                if (l !== el) report("left", l, el);
                if (r !== er) report("right", r, er);
            end
            results++;
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [23:0] i_left_in = '0;
    logic signed [23:0] i_right_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [23:0] o_left_out;
    logic signed [23:0] o_right_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    tape_delay_scoreboard sb = new();
    int cycles = 0;
    int pairs_sent = 0;
    bit steady = 0;
    int stall_left = 0;

    stereo_tape_delay_top u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[stereo_tape_delay_top] ERROR");
            $finish;
        end
        if (o_out_valid && i_out_ready) sb.check_result(o_left_out, o_right_out);
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            stall_left <= gap_len();
            i_out_ready <= 1'b1;
        end
    end

    task send_pair(logic signed [23:0] l, logic signed [23:0] r);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_left_in <= l;
        i_right_in <= r;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(l, r);
        pairs_sent++;
    endtask

    task drain();
        i_in_valid <= 1'b0;
        while (sb.left_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [47:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function logic [47:0] smooth_filter();
        logic [15:0] b0, a1, a2;
        b0 = 16'($urandom_range(100, 3000));
        a1 = 16'(-$urandom_range(14000, 28000));
        a2 = 16'($urandom_range(4000, 12000));
        return {b0, a1, a2};
    endfunction

    task random_pairs(int n);
        logic signed [23:0] l, r;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 7) begin
                l = 24'($urandom_range(0, 2000000) - 1000000);
                r = 24'($urandom_range(0, 2000000) - 1000000);
            end else begin
                l = 24'($urandom);
                r = 24'($urandom);
            end
            send_pair(l, r);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass-through with reset settings
        steady = 1;
        send_pair(24'sh7FFFFF, -24'sh800000);
        send_pair(-24'sh800000, 24'sh7FFFFF);
        send_pair(24'sh000000, -24'sh000001);
        send_pair(24'sh555555, 24'shAAAAAA);
        steady = 0;
        drain();
        write_cfg(CFG_WET_GAIN, 48'd32);
        send_pair(24'sh123456, -24'sh123456);
        drain();

        // shortest delay, full feedback, just above the wet floor
        write_cfg(CFG_WET_GAIN, 48'd33);
        write_cfg(CFG_BASE_DELAY, 48'd256);
        write_cfg(CFG_FEEDBACK_GAIN, 48'd32768);
        write_cfg(CFG_TONE_FILTER, {16'sd16384, 16'sd0, 16'sd0});
        write_cfg(CFG_LOOP_FILTER, {16'sd16384, 16'sd0, 16'sd0});
        write_cfg(CFG_SPARE, {48{1'b1}});
        for (int i = 0; i < 6; i++) send_pair(24'sh7FFFFF, -24'sh800000);
        drain();

        // gains over unity, longest delay, full flutter, wild filters
        write_cfg(CFG_WET_GAIN, 48'hFFFF);
        write_cfg(CFG_FEEDBACK_GAIN, 48'hFFFF);
        write_cfg(CFG_BASE_DELAY, 48'd33553920);
        write_cfg(CFG_FLUTTER_DEPTH, 48'd1311);
        write_cfg(CFG_FLUTTER_STEP, 48'hFFFFFF);
        write_cfg(CFG_TONE_FILTER, {48{1'b1}});
        write_cfg(CFG_LOOP_FILTER, 48'h7FFF_8000_7FFF);
        for (int i = 0; i < 8; i++) send_pair(24'($urandom), 24'($urandom));
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            write_cfg(CFG_BASE_DELAY, ph == 3 ? 48'($urandom_range(256, 33553920))
                                              : 48'($urandom_range(256, 40 * 256)));
            write_cfg(CFG_FEEDBACK_GAIN, 48'($urandom_range(0, 32768)));
            write_cfg(CFG_WET_GAIN, ph == 5 ? 48'($urandom_range(0, 32))
                                            : 48'($urandom_range(33, 32768)));
            write_cfg(CFG_FLUTTER_DEPTH, 48'($urandom_range(0, 1311)));
            write_cfg(CFG_FLUTTER_STEP, ph == 2 ? 48'($urandom & 24'hFFFFFF)
                                                : 48'($urandom_range(0, 200000)));
            write_cfg(CFG_TONE_FILTER, ph == 4 ? {$urandom, 16'($urandom)} : smooth_filter());
            write_cfg(CFG_LOOP_FILTER, ph == 4 ? {$urandom, 16'($urandom)} : smooth_filter());
            steady = (ph == 1);
            random_pairs(25);
            if (ph == 0) begin
                drain();
            end
            random_pairs(30);
            steady = 0;
            drain();
        end

        $display("sent %0d sample pairs and checked %0d output pairs over", pairs_sent,
                 sb.results);
        $display("pass-through, delay extremes, gain overrange, flutter and filter saturation");
        if (sb.errors == 0) begin
            $display("[stereo_tape_delay_top] OK");
        end else begin
            $display("[stereo_tape_delay_top] ERROR");
        end
        $finish;
    end
endmodule
